### rtl/owbm_pkg.sv
// Shared types and constants for the single-wire bus master.
// Used by owbm_regs, owbm_core and one_wire_bus_master; depends on nothing.
package owbm_pkg;

    localparam int unsigned TICK_W   = 10;
    localparam int unsigned NUM_REGS = 7;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned DATA_W   = 32;

    localparam logic [TICK_W-1:0] PRESENCE_WAIT_MAX = 10'd200;
    localparam logic [TICK_W-1:0] PRESENCE_LOW_MAX  = 10'd240;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [IDX_W-1:0] REG_RESET_RELEASE = 3'd1;
    localparam logic [IDX_W-1:0] REG_SLOT_START    = 3'd2;
    localparam logic [IDX_W-1:0] REG_WRITE_HOLD    = 3'd3;
    localparam logic [IDX_W-1:0] REG_WRITE_REC     = 3'd4;
    localparam logic [IDX_W-1:0] REG_READ_SAMPLE   = 3'd5;
    localparam logic [IDX_W-1:0] REG_READ_REC      = 3'd6;

    localparam logic [TICK_W-1:0] RST_RESET_LOW     = 10'd490;
    localparam logic [TICK_W-1:0] RST_RESET_RELEASE = 10'd28;
    localparam logic [TICK_W-1:0] RST_SLOT_START    = 10'd4;
    localparam logic [TICK_W-1:0] RST_WRITE_HOLD    = 10'd58;
    localparam logic [TICK_W-1:0] RST_WRITE_REC     = 10'd5;
    localparam logic [TICK_W-1:0] RST_READ_SAMPLE   = 10'd2;
    localparam logic [TICK_W-1:0] RST_READ_REC      = 10'd55;

    // Command codes.
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Status codes.
    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_NO_PRESENCE = 2'd1;
    localparam logic [1:0] STAT_STUCK_LOW   = 2'd2;

    typedef enum logic [10:0] {
        PH_IDLE      = 11'b000_0000_0001,
        PH_RST_LOW   = 11'b000_0000_0010,
        PH_RST_REL   = 11'b000_0000_0100,
        PH_PRES_WAIT = 11'b000_0000_1000,
        PH_PRES_LOW  = 11'b000_0001_0000,
        PH_W_START   = 11'b000_0010_0000,
        PH_W_HOLD    = 11'b000_0100_0000,
        PH_W_REC     = 11'b000_1000_0000,
        PH_R_START   = 11'b001_0000_0000,
        PH_R_SAMPLE  = 11'b010_0000_0000,
        PH_R_REC     = 11'b100_0000_0000
    } t_phase;

    typedef struct packed {
        logic [TICK_W-1:0] reset_low;
        logic [TICK_W-1:0] reset_release;
        logic [TICK_W-1:0] slot_start;
        logic [TICK_W-1:0] write_hold;
        logic [TICK_W-1:0] write_rec;
        logic [TICK_W-1:0] read_sample;
        logic [TICK_W-1:0] read_rec;
    } t_cfg;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] write_data;
        logic       line_level;
    } t_item;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic [1:0] status;
    } t_result;

endpackage

### rtl/owbm_regs.sv
// Timing register bank with its APB-style access port.
// Depends on owbm_pkg.
module owbm_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [owbm_pkg::ADDR_W-1:0] paddr,
    input  logic [owbm_pkg::DATA_W-1:0] pwdata,
    output logic [owbm_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output owbm_pkg::t_cfg             o_cfg
);
    import owbm_pkg::*;

    t_cfg             r_cfg;
    logic             wr_en;
    logic [IDX_W-1:0] idx;
    logic [TICK_W-1:0] rd_val;
    logic [TICK_W-1:0] wr_val;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_val = pwdata[TICK_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low     <= RST_RESET_LOW;
            r_cfg.reset_release <= RST_RESET_RELEASE;
            r_cfg.slot_start    <= RST_SLOT_START;
            r_cfg.write_hold    <= RST_WRITE_HOLD;
            r_cfg.write_rec     <= RST_WRITE_REC;
            r_cfg.read_sample   <= RST_READ_SAMPLE;
            r_cfg.read_rec      <= RST_READ_REC;
        end else if (wr_en) begin
            case (idx)
                REG_RESET_LOW:     r_cfg.reset_low     <= wr_val;
                REG_RESET_RELEASE: r_cfg.reset_release <= wr_val;
                REG_SLOT_START:    r_cfg.slot_start    <= wr_val;
                REG_WRITE_HOLD:    r_cfg.write_hold    <= wr_val;
                REG_WRITE_REC:     r_cfg.write_rec     <= wr_val;
                REG_READ_SAMPLE:   r_cfg.read_sample   <= wr_val;
                REG_READ_REC:      r_cfg.read_rec      <= wr_val;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_RESET_LOW:     rd_val = r_cfg.reset_low;
            REG_RESET_RELEASE: rd_val = r_cfg.reset_release;
            REG_SLOT_START:    rd_val = r_cfg.slot_start;
            REG_WRITE_HOLD:    rd_val = r_cfg.write_hold;
            REG_WRITE_REC:     rd_val = r_cfg.write_rec;
            REG_READ_SAMPLE:   rd_val = r_cfg.read_sample;
            REG_READ_REC:      rd_val = r_cfg.read_rec;
            default:           rd_val = '0;
        endcase
    end

    assign prdata = {{(DATA_W-TICK_W){1'b0}}, rd_val};
    assign o_cfg  = r_cfg;

endmodule

### rtl/owbm_core.sv
// Bus sequencer: phase, tick counter, bit index and shift byte, one tick per transaction.
// Depends on owbm_pkg; timing comes from owbm_regs.
module owbm_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  owbm_pkg::t_item   i_item,
    input  owbm_pkg::t_cfg    i_cfg,
    output owbm_pkg::t_result o_result
);
    import owbm_pkg::*;

    t_phase            r_phase,  n_phase;
    logic [TICK_W-1:0] r_tick,   n_tick;
    logic [2:0]        r_bit,    n_bit;
    logic [7:0]        r_shift,  n_shift;
    logic [1:0]        r_status, n_status;
    logic [7:0]        r_read,   n_read;

    t_phase            cur;
    logic [TICK_W-1:0] limit;
    logic [TICK_W-1:0] cnt_inc;
    logic              cnt_hit;
    logic              drive;
    logic              busy;
    logic              done;

    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_status = r_status;
        n_read   = r_read;
        drive    = 1'b0;
        busy     = 1'b0;
        done     = 1'b0;

        // A command is taken only in idle, and its tick already counts.
        if (r_phase == PH_IDLE && i_item.command != CMD_NONE) begin
            n_tick = '0;
            n_bit  = '0;
            case (i_item.command)
                CMD_RESET: n_phase = PH_RST_LOW;
                CMD_WRITE: begin
                    n_shift = i_item.write_data;
                    n_phase = PH_W_START;
                end
                default: begin
                    n_shift = '0;
                    n_phase = PH_R_START;
                end
            endcase
        end

        cur = n_phase;

        case (cur)
            PH_RST_LOW:                limit = i_cfg.reset_low;
            PH_RST_REL:                limit = i_cfg.reset_release;
            PH_PRES_WAIT:              limit = PRESENCE_WAIT_MAX;
            PH_PRES_LOW:               limit = PRESENCE_LOW_MAX;
            PH_W_START, PH_R_START:    limit = i_cfg.slot_start;
            PH_W_HOLD:                 limit = i_cfg.write_hold;
            PH_W_REC:                  limit = i_cfg.write_rec;
            PH_R_SAMPLE:               limit = i_cfg.read_sample;
            PH_R_REC:                  limit = i_cfg.read_rec;
            default:                   limit = '1;
        endcase

        cnt_inc = n_tick + 1'b1;
        cnt_hit = (cnt_inc >= limit);
        busy    = (cur != PH_IDLE);

        case (cur)
            PH_RST_LOW: begin
                drive  = 1'b1;
                n_tick = cnt_hit ? '0 : cnt_inc;
                if (cnt_hit) n_phase = PH_RST_REL;
            end
            PH_RST_REL: begin
                n_tick = cnt_hit ? '0 : cnt_inc;
                if (cnt_hit) n_phase = PH_PRES_WAIT;
            end
            PH_PRES_WAIT: begin
                if (!i_item.line_level) begin
                    n_tick  = '0;
                    n_phase = PH_PRES_LOW;
                end else begin
                    n_tick = cnt_hit ? '0 : cnt_inc;
                    if (cnt_hit) begin
                        n_status = STAT_NO_PRESENCE;
                        n_phase  = PH_IDLE;
                        done     = 1'b1;
                    end
                end
            end
            PH_PRES_LOW: begin
                if (i_item.line_level) begin
                    n_tick   = '0;
                    n_status = STAT_OK;
                    n_phase  = PH_IDLE;
                    done     = 1'b1;
                end else begin
                    n_tick = cnt_hit ? '0 : cnt_inc;
                    if (cnt_hit) begin
                        n_status = STAT_STUCK_LOW;
                        n_phase  = PH_IDLE;
                        done     = 1'b1;
                    end
                end
            end
            PH_W_START: begin
                drive  = 1'b1;
                n_tick = cnt_hit ? '0 : cnt_inc;
                if (cnt_hit) n_phase = PH_W_HOLD;
            end
            PH_W_HOLD: begin
                drive  = ~n_shift[0];
                n_tick = cnt_hit ? '0 : cnt_inc;
                if (cnt_hit) n_phase = PH_W_REC;
            end
            PH_W_REC: begin
                n_tick = cnt_hit ? '0 : cnt_inc;
                if (cnt_hit) begin
                    if (n_bit == 3'd7) begin
                        n_bit   = '0;
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end else begin
                        n_bit   = n_bit + 1'b1;
                        n_shift = {1'b0, n_shift[7:1]};
                        n_phase = PH_W_START;
                    end
                end
            end
            PH_R_START: begin
                drive  = 1'b1;
                n_tick = cnt_hit ? '0 : cnt_inc;
                if (cnt_hit) n_phase = PH_R_SAMPLE;
            end
            PH_R_SAMPLE: begin
                n_tick = cnt_hit ? '0 : cnt_inc;
                if (cnt_hit) begin
                    n_shift = {i_item.line_level, n_shift[7:1]};
                    n_phase = PH_R_REC;
                end
            end
            PH_R_REC: begin
                n_tick = cnt_hit ? '0 : cnt_inc;
                if (cnt_hit) begin
                    if (n_bit == 3'd7) begin
                        n_bit   = '0;
                        n_read  = n_shift;
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end else begin
                        n_bit   = n_bit + 1'b1;
                        n_phase = PH_R_START;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                busy    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_tick   <= '0;
            r_bit    <= '0;
            r_shift  <= '0;
            r_status <= STAT_OK;
            r_read   <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_bit    <= n_bit;
            r_shift  <= n_shift;
            r_status <= n_status;
            r_read   <= n_read;
        end
    end

    assign o_result.drive_low = drive;
    assign o_result.busy_res  = busy;
    assign o_result.done_res  = done;
    assign o_result.read_data = n_read;
    assign o_result.status    = n_status;

    // An operation that finishes leaves the sequencer idle for the next tick.
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && done) |=> (r_phase == PH_IDLE))
        else $error("sequencer not idle after an operation finished");

    // The bit index only advances inside a byte operation.
    a_bit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_bit == 3'd0))
        else $error("bit index left nonzero in idle");

    // Driving the line or finishing only happens inside an operation.
    a_busy_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (drive || done) |-> busy)
        else $error("line driven or done flagged outside an operation");

    // Status changes only when a reset operation finishes.
    a_status_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !(done && (cur == PH_PRES_WAIT || cur == PH_PRES_LOW)))
            |=> $stable(r_status))
        else $error("status changed outside a presence result");

endmodule

### rtl/one_wire_bus_master.sv
// Single-wire bus master top level: input stage, sequencer, result stage, register port.
// Depends on owbm_pkg, owbm_regs and owbm_core.
//
// Each input transaction is one bus tick carrying an optional command and the sampled
// line level; each one yields exactly one result transaction. The block takes one
// transaction per clock cycle while its output is not stalled: a tick goes through an
// input register, the sequencer evaluates it combinationally and the result lands in an
// output register. A stalled output holds the result register; the input register then
// takes at most one more transaction and raises o_stall while it holds it. The sequencer
// state only moves when a tick passes into the result register. Timing registers are
// written through the APB-style port and should only be changed while no operation runs.
module one_wire_bus_master (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_command,
    input  logic [7:0]                  i_write_data,
    input  logic                        i_line_level,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_drive_low,
    output logic                        o_busy_res,
    output logic                        o_done_res,
    output logic [7:0]                  o_read_data,
    output logic [1:0]                  o_status,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [owbm_pkg::ADDR_W-1:0] paddr,
    input  logic [owbm_pkg::DATA_W-1:0] pwdata,
    output logic [owbm_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import owbm_pkg::*;

    t_cfg    cfg;
    t_result res;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_res;
    logic    fire;
    logic    load;

    owbm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    owbm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (res)
    );

    assign fire    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !fire;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in_item.command    <= i_command;
            r_in_item.write_data <= i_write_data;
            r_in_item.line_level <= i_line_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_res <= res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_drive_low = r_out_res.drive_low;
    assign o_busy_res  = r_out_res.busy_res;
    assign o_done_res  = r_out_res.done_res;
    assign o_read_data = r_out_res.read_data;
    assign o_status    = r_out_res.status;

    // A full result register under stall must keep its transaction.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_out_res)))
        else $error("result register lost a stalled transaction");

    // The sequencer only advances when an input tick is present.
    a_fire_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> r_in_valid)
        else $error("sequencer advanced without an input tick");

    // A held input transaction stays in place until the sequencer takes it.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> (r_in_valid && $stable(r_in_item)))
        else $error("input register lost a stalled transaction");

endmodule

### tb/sv/one_wire_bus_master_tb.sv
// Self-checking testbench for the single-wire bus master: drives tick transactions,
// programs the timing registers over the APB-style port and checks every result.
// Depends on owbm_pkg and the one_wire_bus_master RTL.
module one_wire_bus_master_tb;
    import owbm_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_TICKS  = 40;
    localparam int PRINT_LIMIT   = 40;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_valid      = 1'b0;
    logic                 o_stall;
    logic [1:0]           i_command    = CMD_NONE;
    logic [7:0]           i_write_data = 8'h00;
    logic                 i_line_level = 1'b1;
    logic                 o_valid;
    logic                 i_stall      = 1'b0;
    logic                 o_drive_low;
    logic                 o_busy_res;
    logic                 o_done_res;
    logic [7:0]           o_read_data;
    logic [1:0]           o_status;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [ADDR_W-1:0]    paddr        = '0;
    logic [DATA_W-1:0]    pwdata       = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    one_wire_bus_master dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mirror of the sequencer state, advanced once per accepted tick.
    t_phase      bus_phase = PH_IDLE;
    logic [9:0]  tick_cnt  = '0;
    logic [2:0]  bit_idx   = '0;
    logic [7:0]  shift_q   = '0;
    logic [1:0]  status_q  = STAT_OK;
    logic [7:0]  rd_byte   = '0;
    t_cfg        timing    = {RST_RESET_LOW, RST_RESET_RELEASE, RST_SLOT_START,
                              RST_WRITE_HOLD, RST_WRITE_REC, RST_READ_SAMPLE,
                              RST_READ_REC};

    t_result     bus_outputs_q[$];
    int          mismatches    = 0;
    int          results_seen  = 0;
    int          ticks_sent    = 0;
    int          op_ticks      = 0;
    int          ops_by_cmd[4] = '{0, 0, 0, 0};
    int          status_seen[4] = '{0, 0, 0, 0};
    int          tx_gap_max    = 13;
    int          rx_gap_max    = 13;
    int          rx_hold_cycles = 0;

    function automatic bit period_over(logic [9:0] limit);
        tick_cnt = tick_cnt + 10'd1;
        if (tick_cnt >= limit) begin
            tick_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_result step_bus_master(logic [1:0] cmd, logic [7:0] wdat, logic line);
        t_result r;
        r = '0;
        if (bus_phase == PH_IDLE && cmd != CMD_NONE) begin
            tick_cnt = '0;
            bit_idx  = '0;
            case (cmd)
                CMD_RESET: bus_phase = PH_RST_LOW;
                CMD_WRITE: begin
                    shift_q   = wdat;
                    bus_phase = PH_W_START;
                end
                default: begin
                    shift_q   = '0;
                    bus_phase = PH_R_START;
                end
            endcase
        end
        r.busy_res = (bus_phase != PH_IDLE);
        case (bus_phase)
            PH_RST_LOW: begin
                r.drive_low = 1'b1;
                if (period_over(timing.reset_low)) bus_phase = PH_RST_REL;
            end
            PH_RST_REL: begin
                if (period_over(timing.reset_release)) bus_phase = PH_PRES_WAIT;
            end
            PH_PRES_WAIT: begin
                if (!line) begin
                    tick_cnt  = '0;
                    bus_phase = PH_PRES_LOW;
                end else if (period_over(PRESENCE_WAIT_MAX)) begin
                    status_q   = STAT_NO_PRESENCE;
                    bus_phase  = PH_IDLE;
                    r.done_res = 1'b1;
                end
            end
            PH_PRES_LOW: begin
                if (line) begin
                    tick_cnt   = '0;
                    status_q   = STAT_OK;
                    bus_phase  = PH_IDLE;
                    r.done_res = 1'b1;
                end else if (period_over(PRESENCE_LOW_MAX)) begin
                    status_q   = STAT_STUCK_LOW;
                    bus_phase  = PH_IDLE;
                    r.done_res = 1'b1;
                end
            end
            PH_W_START: begin
                r.drive_low = 1'b1;
                if (period_over(timing.slot_start)) bus_phase = PH_W_HOLD;
            end
            PH_W_HOLD: begin
                r.drive_low = ~shift_q[0];
                if (period_over(timing.write_hold)) bus_phase = PH_W_REC;
            end
            PH_W_REC: begin
                if (period_over(timing.write_rec)) begin
                    if (bit_idx == 3'd7) begin
                        bit_idx    = '0;
                        bus_phase  = PH_IDLE;
                        r.done_res = 1'b1;
                    end else begin
                        bit_idx   = bit_idx + 3'd1;
                        shift_q   = shift_q >> 1;
                        bus_phase = PH_W_START;
                    end
                end
            end
            PH_R_START: begin
                r.drive_low = 1'b1;
                if (period_over(timing.slot_start)) bus_phase = PH_R_SAMPLE;
            end
            PH_R_SAMPLE: begin
                // The bit is taken on the last tick of the release and enters at the top.
                if (period_over(timing.read_sample)) begin
                    shift_q   = {line, shift_q[7:1]};
                    bus_phase = PH_R_REC;
                end
            end
            PH_R_REC: begin
                if (period_over(timing.read_rec)) begin
                    if (bit_idx == 3'd7) begin
                        bit_idx    = '0;
                        rd_byte    = shift_q;
                        bus_phase  = PH_IDLE;
                        r.done_res = 1'b1;
                    end else begin
                        bit_idx   = bit_idx + 3'd1;
                        bus_phase = PH_R_START;
                    end
                end
            end
            default: begin
                bus_phase  = PH_IDLE;
                r.busy_res = 1'b0;
            end
        endcase
        r.read_data = rd_byte;
        r.status    = status_q;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at result %0d, %s: got %0h, expected %0h",
                     results_seen, what, got, want);
    endtask

    task automatic send_tick(input logic [1:0] cmd, input logic [7:0] wdat, input logic line);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command    <= cmd;
        i_write_data <= wdat;
        i_line_level <= line;
        i_valid      <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bus_outputs_q.push_back(step_bus_master(cmd, wdat, line));
        ticks_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (bus_outputs_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input int idx, input logic [31:0] value);
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_RESET_LOW:     timing.reset_low     = value[9:0];
            REG_RESET_RELEASE: timing.reset_release = value[9:0];
            REG_SLOT_START:    timing.slot_start    = value[9:0];
            REG_WRITE_HOLD:    timing.write_hold    = value[9:0];
            REG_WRITE_REC:     timing.write_rec     = value[9:0];
            REG_READ_SAMPLE:   timing.read_sample   = value[9:0];
            REG_READ_REC:      timing.read_rec      = value[9:0];
            default: ;
        endcase
    endtask

    task automatic check_all_regs();
        logic [9:0] want;
        for (int i = 0; i < NUM_REGS; i++) begin
            case (i)
                REG_RESET_LOW:     want = timing.reset_low;
                REG_RESET_RELEASE: want = timing.reset_release;
                REG_SLOT_START:    want = timing.slot_start;
                REG_WRITE_HOLD:    want = timing.write_hold;
                REG_WRITE_REC:     want = timing.write_rec;
                REG_READ_SAMPLE:   want = timing.read_sample;
                default:           want = timing.read_rec;
            endcase
            paddr   <= ADDR_W'(i * 4);
            pwrite  <= 1'b0;
            psel    <= 1'b1;
            penable <= 1'b0;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            if (prdata !== DATA_W'(want))
                report_mismatch($sformatf("register %0d read back", i), prdata, want);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic set_all_regs(input logic [31:0] value);
        wait_drained();
        for (int i = 0; i < NUM_REGS; i++) cfg_write(i, value);
    endtask

    // One full operation: the command tick, then ticks until the sequencer is idle again.
    // The presence reply is shaped by the number of released samples before the slave
    // pulls low and the number of low samples it holds; a noisy line is random throughout.
    task automatic run_op(input logic [1:0] cmd, input logic [7:0] wdat, input bit noisy,
                          input int pres_delay, input int pres_low);
        int         waited;
        int         held;
        logic       line;
        logic [1:0] stray_cmd;
        waited = 0;
        held   = 0;
        send_tick(cmd, wdat, 1'($urandom));
        op_ticks++;
        while (bus_phase != PH_IDLE) begin
            line = 1'($urandom);
            if (!noisy && bus_phase == PH_PRES_WAIT) begin
                line = (waited < pres_delay);
                waited++;
            end else if (!noisy && bus_phase == PH_PRES_LOW) begin
                line = (held >= pres_low);
                held++;
            end
            // Commands offered mid-operation must be ignored.
            stray_cmd = ($urandom_range(0, 3) == 0) ? 2'($urandom) : CMD_NONE;
            send_tick(stray_cmd, 8'($urandom), line);
            op_ticks++;
        end
        ops_by_cmd[cmd]++;
        if (cmd == CMD_RESET) status_seen[status_q]++;
    endtask

    task automatic test_defaults();
        check_all_regs();
        repeat (4) send_tick(CMD_NONE, 8'($urandom), 1'($urandom));
    endtask

    task automatic test_zero_timing();
        // Upper data bits are dropped, so every register ends up at zero.
        set_all_regs(32'hFFFF_FC00);
        cfg_write(NUM_REGS, 32'h0000_03FF);
        check_all_regs();
        run_op(CMD_RESET, 8'h00, 1'b0, 0, 0);
        run_op(CMD_WRITE, 8'h5C, 1'b0, 0, 0);
        run_op(CMD_READ, 8'h5A, 1'b1, 0, 0);
    endtask

    task automatic test_presence_limits();
        set_all_regs(32'd1);
        tx_gap_max = 3;
        rx_gap_max = 3;
        run_op(CMD_RESET, 8'h00, 1'b0, PRESENCE_WAIT_MAX, 0);
        run_op(CMD_RESET, 8'h00, 1'b0, 0, PRESENCE_LOW_MAX);
        // A stuck-low status must survive the byte operation that follows.
        run_op(CMD_READ, 8'h00, 1'b1, 0, 0);
        run_op(CMD_RESET, 8'h00, 1'b0, 2, 3);
    endtask

    task automatic test_max_timing();
        set_all_regs(32'h0000_03FF);
        check_all_regs();
    endtask

    task automatic test_backpressure();
        set_all_regs(32'd1);
        tx_gap_max     = 0;
        rx_gap_max     = 0;
        rx_hold_cycles = 300;
        run_op(CMD_WRITE, 8'($urandom), 1'b0, 0, 0);
        wait_drained();
        rx_gap_max = 13;
        run_op(CMD_RESET, 8'h00, 1'b0, 4, 6);
    endtask

    task automatic test_random_traffic();
        int         start_ticks;
        int         pick;
        logic [1:0] cmd;
        start_ticks = op_ticks;
        wait_drained();
        for (int i = 0; i < NUM_REGS; i++)
            cfg_write(i, $urandom_range(0, 2));
        tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 13;
        rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 13;
        while (op_ticks - start_ticks < RANDOM_TICKS) begin
            repeat ($urandom_range(0, 3)) send_tick(CMD_NONE, 8'($urandom), 1'($urandom));
            cmd  = 2'($urandom_range(1, 3));
            pick = $urandom_range(0, 4);
            run_op(cmd, 8'($urandom), (pick == 0), $urandom_range(0, 15),
                   $urandom_range(0, 15));
        end
    endtask

    // Result side: random stall before each transaction, then compare with the oldest
    // expectation.
    initial begin : result_checker
        int      n;
        t_result want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                n = $urandom_range(0, rx_gap_max);
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            if (bus_outputs_q.size() == 0) begin
                report_mismatch("result with nothing expected", 0, 0);
            end else begin
                want = bus_outputs_q.pop_front();
                if (o_drive_low !== want.drive_low)
                    report_mismatch("drive_low", o_drive_low, want.drive_low);
                if (o_busy_res !== want.busy_res)
                    report_mismatch("busy", o_busy_res, want.busy_res);
                if (o_done_res !== want.done_res)
                    report_mismatch("done", o_done_res, want.done_res);
                if (o_read_data !== want.read_data)
                    report_mismatch("read_data", o_read_data, want.read_data);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
            end
            results_seen++;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (!i_rst_n) @(posedge i_clk);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("[one_wire_bus_master] ERROR");
        $finish;
    end

    initial begin : main
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_zero_timing();
        test_presence_limits();
        test_max_timing();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (bus_outputs_q.size() != 0)
            report_mismatch("results never delivered", 0, bus_outputs_q.size());
        $display("covered %0d ticks, %0d results: %0d reset, %0d write, %0d read operations",
                 ticks_sent, results_seen, ops_by_cmd[CMD_RESET], ops_by_cmd[CMD_WRITE],
                 ops_by_cmd[CMD_READ]);
        $display("reset outcomes: %0d present, %0d absent, %0d stuck low; %0d mismatches",
                 status_seen[STAT_OK], status_seen[STAT_NO_PRESENCE],
                 status_seen[STAT_STUCK_LOW], mismatches);
        if (mismatches == 0)
            $display("[one_wire_bus_master] OK");
        else
            $display("[one_wire_bus_master] ERROR");
        $finish;
    end

endmodule
